### src/pll_pkg.sv
// Shared constants and codes for the positional linked list engine.
package pll_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int FUNC_W   = 2;
    localparam int POS_W    = 16;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

endpackage

### src/pll_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/pll_link_store.sv
// Next-link store: RAM plus per-node valid bits; unwritten nodes read as the free chain.
module pll_link_store #(
    parameter int CAPACITY = 16,
    parameter int PW       = $clog2(CAPACITY + 1),
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [PW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [PW-1:0] rdata
);

    logic [CAPACITY-1:0] vld_reg;
    logic                rd_vld_reg;
    logic [AW-1:0]       rd_addr_reg;
    logic [PW-1:0]       ram_q;

    pll_ram #(
        .WIDTH (PW),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_addr_reg <= '0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            // old valid bit on read-during-write, matching the RAM
            rd_vld_reg  <= vld_reg[raddr];
            rd_addr_reg <= raddr;
        end
    end

    // reset chain: node i links to i+1, last node to null (CAPACITY)
    assign rdata = rd_vld_reg ? ram_q : (PW'(rd_addr_reg) + PW'(1));

endmodule

### src/positional_linked_list_engine_top.sv
// Positional linked list engine: top level with the list sequencer.
//
// Keeps an ordered list of signed 32-bit values in a pool of CAPACITY nodes.
// Input channel s_*: one item per operation (insert at position, delete at
// position, dump). Output channel m_*: one result item per insert or delete
// with tlast set; a dump gives one result per element from head to tail,
// tlast on the final one, or a single empty-status result.
// One item at a time: s_tready is high only while the sequencer is idle.
// The link store is read once per cycle. An insert or delete at position
// p >= 2 walks the list from the head to the node before p; an insert at
// the head links the new node in directly, a delete at the head unlinks
// the head node; an out-of-range, full or empty result is loaded straight
// after decode. A dump loads one result per cycle while the output is free.
// The result sits in an output register; the next item is accepted the cycle
// after the last result is loaded, while it waits. If the receiver stalls,
// the sequencer holds its next result and a dump's walk pauses with it.
// Reset empties the list and chains all nodes into the free list at once;
// the block is ready as soon as reset is released.
module positional_linked_list_engine_top #(
    parameter int CAPACITY = pll_pkg::DEFAULT_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // func[1:0], position[17:2], value[49:18], zero fill
    input  logic [pll_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], item_value[33:2], zero fill
    output logic [pll_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    import pll_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [PW-1:0] NULL_PTR = PW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_FREE,
        S_WALK,
        S_INS_PRED,
        S_DEL_HEAD,
        S_DEL_VIC,
        S_DEL_FREE,
        S_DUMP,
        S_FINISH
    } state_t;

    state_t                   state_reg;
    logic [FUNC_W-1:0]        func_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [VAL_W-1:0]  val_reg;
    logic [PW-1:0]            head_reg;
    logic [PW-1:0]            free_reg;
    logic [PW-1:0]            count_reg;
    logic [PW-1:0]            p_reg;
    logic [PW-1:0]            n_reg;
    logic [PW-1:0]            vic_reg;
    logic [PW-1:0]            steps_reg;
    logic [STATUS_W-1:0]      res_status_reg;
    logic                     out_valid_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic signed [VAL_W-1:0]  out_value_reg;
    logic                     out_last_reg;

    logic [PW-1:0]            rd_ptr;
    logic                     link_we;
    logic [PW-1:0]            link_waddr;
    logic [PW-1:0]            link_wdata;
    logic [PW-1:0]            link_q;
    logic                     val_we;
    logic [VAL_W-1:0]         val_q;

    logic                     out_free;
    logic                     out_load;
    logic [POS_W:0]           pos_ext;
    logic [POS_W:0]           cnt_ext;
    logic [PW-1:0]            walk_steps;

    assign out_free   = !out_valid_reg || m_tready;
    // a new result goes into the output register this cycle
    assign out_load   = out_free && (state_reg == S_DUMP || state_reg == S_FINISH);
    assign pos_ext    = {1'b0, pos_reg};
    assign cnt_ext    = (POS_W + 1)'(count_reg);
    // position is at least 2 and at most CAPACITY when this is used
    assign walk_steps = PW'(pos_reg - POS_W'(2));

    pll_link_store #(
        .CAPACITY (CAPACITY),
        .PW       (PW),
        .AW       (AW)
    ) u_links (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (link_we),
        .waddr (link_waddr[AW-1:0]),
        .wdata (link_wdata),
        .raddr (rd_ptr[AW-1:0]),
        .rdata (link_q)
    );

    pll_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_values (
        .clk   (clk),
        .we    (val_we),
        .waddr (free_reg[AW-1:0]),
        .wdata (val_reg),
        .raddr (rd_ptr[AW-1:0]),
        .rdata (val_q)
    );

    // memory control
    always_comb
    begin
        rd_ptr     = p_reg;
        link_we    = 1'b0;
        link_waddr = n_reg;
        link_wdata = link_q;
        val_we     = 1'b0;
        unique case (state_reg)
            S_DECODE:
            begin
                unique case (func_reg)
                    FUNC_INSERT: rd_ptr = free_reg;
                    default:     rd_ptr = head_reg;
                endcase
            end
            S_INS_FREE:
            begin
                val_we = 1'b1;
                rd_ptr = head_reg;
                if (pos_reg == POS_W'(1))
                begin
                    link_we    = 1'b1;
                    link_waddr = free_reg;
                    link_wdata = head_reg;
                end
            end
            S_WALK:
            begin
                if (steps_reg != '0)
                begin
                    rd_ptr = link_q;
                end
                else if (func_reg == FUNC_INSERT)
                begin
                    link_we    = 1'b1;
                    link_waddr = n_reg;
                    link_wdata = link_q;
                end
                else
                begin
                    rd_ptr = link_q;
                end
            end
            S_INS_PRED:
            begin
                link_we    = 1'b1;
                link_waddr = p_reg;
                link_wdata = n_reg;
            end
            S_DEL_VIC:
            begin
                link_we    = 1'b1;
                link_waddr = p_reg;
                link_wdata = link_q;
            end
            S_DEL_FREE:
            begin
                link_we    = 1'b1;
                link_waddr = vic_reg;
                link_wdata = free_reg;
            end
            S_DUMP:
            begin
                if (out_free && count_reg != PW'(1))
                begin
                    rd_ptr = link_q;
                end
            end
            default:
            begin
                rd_ptr = p_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            func_reg       <= FUNC_INSERT;
            pos_reg        <= '0;
            val_reg        <= '0;
            head_reg       <= NULL_PTR;
            free_reg       <= '0;
            count_reg      <= '0;
            p_reg          <= '0;
            n_reg          <= '0;
            vic_reg        <= '0;
            steps_reg      <= '0;
            res_status_reg <= STATUS_OK;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OK;
            out_value_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (m_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        func_reg  <= s_tdata[FUNC_W-1:0];
                        pos_reg   <= s_tdata[FUNC_W +: POS_W];
                        val_reg   <= s_tdata[FUNC_W + POS_W +: VAL_W];
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    p_reg     <= head_reg;
                    steps_reg <= (func_reg == FUNC_DUMP) ? count_reg : walk_steps;
                    unique case (func_reg)
                        FUNC_INSERT:
                        begin
                            if (count_reg >= PW'(CAPACITY) || free_reg >= NULL_PTR)
                            begin
                                res_status_reg <= STATUS_FULL;
                                state_reg      <= S_FINISH;
                            end
                            else if (pos_reg == '0 || pos_ext > cnt_ext + (POS_W + 1)'(1))
                            begin
                                res_status_reg <= STATUS_RANGE;
                                state_reg      <= S_FINISH;
                            end
                            else
                            begin
                                state_reg <= S_INS_FREE;
                            end
                        end
                        FUNC_DELETE:
                        begin
                            if (pos_reg == '0 || pos_ext > cnt_ext)
                            begin
                                res_status_reg <= STATUS_RANGE;
                                state_reg      <= S_FINISH;
                            end
                            else if (pos_reg == POS_W'(1))
                            begin
                                state_reg <= S_DEL_HEAD;
                            end
                            else
                            begin
                                state_reg <= S_WALK;
                            end
                        end
                        FUNC_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_reg <= STATUS_EMPTY;
                                state_reg      <= S_FINISH;
                            end
                            else
                            begin
                                state_reg <= S_DUMP;
                            end
                        end
                        default:
                        begin
                            res_status_reg <= STATUS_OK;
                            state_reg      <= S_FINISH;
                        end
                    endcase
                end
                S_INS_FREE:
                begin
                    n_reg    <= free_reg;
                    free_reg <= link_q;
                    if (pos_reg == POS_W'(1))
                    begin
                        head_reg       <= free_reg;
                        count_reg      <= count_reg + PW'(1);
                        res_status_reg <= STATUS_OK;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    // link_q always holds the link of p_reg here
                    if (steps_reg != '0)
                    begin
                        p_reg     <= link_q;
                        steps_reg <= steps_reg - PW'(1);
                    end
                    else if (func_reg == FUNC_INSERT)
                    begin
                        state_reg <= S_INS_PRED;
                    end
                    else
                    begin
                        vic_reg   <= link_q;
                        state_reg <= S_DEL_VIC;
                    end
                end
                S_INS_PRED:
                begin
                    count_reg      <= count_reg + PW'(1);
                    res_status_reg <= STATUS_OK;
                    state_reg      <= S_FINISH;
                end
                S_DEL_HEAD:
                begin
                    vic_reg   <= head_reg;
                    head_reg  <= link_q;
                    state_reg <= S_DEL_FREE;
                end
                S_DEL_VIC:
                begin
                    state_reg <= S_DEL_FREE;
                end
                S_DEL_FREE:
                begin
                    free_reg       <= vic_reg;
                    count_reg      <= count_reg - PW'(1);
                    res_status_reg <= STATUS_OK;
                    state_reg      <= S_FINISH;
                end
                S_DUMP:
                begin
                    // steps_reg counts the elements still to send
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= STATUS_OK;
                        out_value_reg  <= val_q;
                        out_last_reg   <= (steps_reg == PW'(1));
                        p_reg          <= link_q;
                        steps_reg      <= steps_reg - PW'(1);
                        if (steps_reg == PW'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_value_reg  <= '0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - VAL_W - STATUS_W)'(0), out_value_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

endmodule

### src/pll_checker.sv
// Port-level checks for the positional linked list engine, bound to the top level.
module pll_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pll_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    import pll_pkg::*;

    // one item at a time: the input closes right after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input still ready after an item was accepted");

    // error and empty results are always single and end the item's results
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[STATUS_W-1:0] != STATUS_OK |-> m_tlast)
    else $error("non-ok result without tlast");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[STATUS_W-1:0] != STATUS_OK
            |-> m_tdata[STATUS_W +: VAL_W] == '0)
    else $error("non-ok result carries a value");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind positional_linked_list_engine_top pll_checker u_pll_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
